@@ hw/rtl/sprr_pkg.sv @@
// Shared types and constants of the sprite row run decoder.
`default_nettype none

package sprr_pkg;

  // Longest fully transparent row that is reported.
  localparam int unsigned MAX_WIDTH = 4096;

  localparam logic [15:0] EMPTY_MARK = 16'h8000;
  localparam logic [14:0] PAD_MAX    = 15'h7FFF;
  localparam logic [7:0]  SKIP_INDEX = 8'(256 - 4);

  // Opcode low nibbles
  localparam logic [3:0] NIB_END      = 4'hF;
  localparam logic [3:0] NIB_GDRAW    = 4'h2;
  localparam logic [3:0] NIB_GSKIP    = 4'h3;
  localparam logic [3:0] NIB_DRAW_CNT = 4'h6;
  localparam logic [3:0] NIB_FILL     = 4'h7;
  localparam logic [3:0] NIB_PFILL    = 4'hA;
  localparam logic [3:0] NIB_SHADOW   = 4'hB;
  localparam logic [3:0] NIB_EXT      = 4'hE;

  // Extended opcode high nibbles
  localparam logic [3:0] EXT_KEY1_A = 4'h4;
  localparam logic [3:0] EXT_KEY1_B = 4'h6;
  localparam logic [3:0] EXT_RUN_A  = 4'h5;
  localparam logic [3:0] EXT_RUN_B  = 4'h7;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPCODE,
    PH_COUNT,
    PH_GREATER_LOW,
    PH_PIXELS,
    PH_COLOR
  } phase_e;

  typedef enum logic [1:0] {
    CL_DRAW,
    CL_SKIP,
    CL_FILL
  } cmd_class_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_END,
    OP_COUNT,     // count known from the opcode itself
    OP_TO_COUNT,  // count follows in the next byte
    OP_GREATER,   // count high part in the opcode, low byte follows
    OP_KEY1       // single skip-index pixel
  } op_kind_e;

  typedef struct packed {
    phase_e      phase;
    logic [11:0] pending;
    cmd_class_e  cls;
    logic [14:0] saved_rp;
    logic [11:0] count_high;
  } dec_state_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  pixel_index;
    logic        is_color_key;
    logic [14:0] run_length;
    logic        row_last;
  } run_t;

endpackage

`default_nettype wire

@@ hw/rtl/sprr_step.sv @@
// Combinational decode of one item: next decoder state and optional run.
`default_nettype none

module sprr_step
  import sprr_pkg::*;
(
  input  dec_state_t  st_i,
  input  logic [12:0] row_width_i,
  input  logic        row_start_i,
  input  logic [7:0]  cmd_byte_i,
  input  logic [15:0] left_pad_i,
  input  logic [15:0] right_pad_i,
  output dec_state_t  st_next_o,
  output run_t        run_o
);

  logic [3:0]  lo;
  logic [3:0]  hi;
  op_kind_e    op_kind;
  cmd_class_e  op_cls;
  logic [11:0] op_n;

  logic        use_now;
  logic [11:0] use_n;
  cmd_class_e  use_cls;

  logic        empty_row;
  logic [14:0] lp_sat;
  logic [14:0] rp_sat;
  logic [14:0] width_run;
  logic [15:0] max_w;

  assign lo = cmd_byte_i[3:0];
  assign hi = cmd_byte_i[7:4];

  assign empty_row = (left_pad_i == EMPTY_MARK) || (right_pad_i == EMPTY_MARK);
  assign lp_sat    = left_pad_i[15]  ? PAD_MAX : left_pad_i[14:0];
  assign rp_sat    = right_pad_i[15] ? PAD_MAX : right_pad_i[14:0];
  assign max_w     = 16'(MAX_WIDTH);
  assign width_run = ({3'b000, row_width_i} > max_w) ? max_w[14:0]
                                                     : {2'b00, row_width_i};

  // opcode classification
  always_comb begin
    op_kind = OP_NONE;
    op_cls  = CL_SKIP;
    op_n    = '0;
    if (lo == NIB_END) begin
      op_kind = OP_END;
    end else if (cmd_byte_i[1:0] == 2'b00) begin
      op_kind = OP_COUNT;
      op_cls  = CL_DRAW;
      op_n    = {6'b0, cmd_byte_i[7:2]};
    end else if (cmd_byte_i[1:0] == 2'b01) begin
      op_cls  = CL_SKIP;
      op_n    = {6'b0, cmd_byte_i[7:2]};
      op_kind = (cmd_byte_i[7:2] != 6'd0) ? OP_COUNT : OP_TO_COUNT;
    end else begin
      case (lo) inside
        NIB_GDRAW, NIB_GSKIP: begin
          op_kind = OP_GREATER;
          op_cls  = (lo == NIB_GDRAW) ? CL_DRAW : CL_SKIP;
        end
        NIB_DRAW_CNT, NIB_FILL, NIB_PFILL, NIB_SHADOW: begin
          op_cls  = (lo == NIB_DRAW_CNT) ? CL_DRAW : CL_FILL;
          op_n    = {8'b0, hi};
          op_kind = (hi != 4'd0) ? OP_COUNT : OP_TO_COUNT;
        end
        NIB_EXT: begin
          if (hi == EXT_KEY1_A || hi == EXT_KEY1_B) begin
            op_kind = OP_KEY1;
          end else if (hi == EXT_RUN_A || hi == EXT_RUN_B) begin
            op_kind = OP_TO_COUNT;
            op_cls  = CL_SKIP;
          end
        end
        default: op_kind = OP_NONE;
      endcase
    end
  end

  // a count is complete this item
  always_comb begin
    use_now = 1'b0;
    use_n   = '0;
    use_cls = st_i.cls;
    unique case (st_i.phase)
      PH_OPCODE: begin
        use_now = (op_kind == OP_COUNT);
        use_n   = op_n;
        use_cls = op_cls;
      end
      PH_COUNT: begin
        use_now = 1'b1;
        use_n   = {4'b0, cmd_byte_i};
      end
      PH_GREATER_LOW: begin
        use_now = 1'b1;
        use_n   = st_i.count_high + {4'b0, cmd_byte_i};
      end
      default: use_now = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    st_next_o = st_i;
    if (row_start_i) begin
      if (empty_row) begin
        st_next_o.phase = PH_IDLE;
      end else begin
        st_next_o.saved_rp = rp_sat;
        st_next_o.pending  = '0;
        st_next_o.phase    = PH_OPCODE;
      end
    end else begin
      unique case (st_i.phase)
        PH_OPCODE, PH_COUNT, PH_GREATER_LOW: begin
          if (st_i.phase == PH_OPCODE) begin
            case (op_kind)
              OP_END:      st_next_o.phase = PH_IDLE;
              OP_TO_COUNT: begin
                st_next_o.cls   = op_cls;
                st_next_o.phase = PH_COUNT;
              end
              OP_GREATER: begin
                st_next_o.cls        = op_cls;
                st_next_o.count_high = {hi, 8'h00};
                st_next_o.phase      = PH_GREATER_LOW;
              end
              default: st_next_o.cls = st_i.cls;
            endcase
          end
          if (use_now) begin
            st_next_o.cls = use_cls;
            unique case (use_cls)
              CL_DRAW: begin
                if (use_n != 12'd0) begin
                  st_next_o.pending = use_n;
                  st_next_o.phase   = PH_PIXELS;
                end else begin
                  st_next_o.phase = PH_OPCODE;
                end
              end
              CL_FILL: begin
                st_next_o.pending = use_n;
                st_next_o.phase   = PH_COLOR;
              end
              default: st_next_o.phase = PH_OPCODE;
            endcase
          end
        end
        PH_PIXELS: begin
          if (st_i.pending <= 12'd1) begin
            st_next_o.pending = '0;
            st_next_o.phase   = PH_OPCODE;
          end else begin
            st_next_o.pending = st_i.pending - 12'd1;
          end
        end
        PH_COLOR: st_next_o.phase = PH_OPCODE;
        default:  st_next_o.phase = PH_IDLE;
      endcase
    end
  end

  // result run
  always_comb begin
    run_o = '0;
    if (row_start_i) begin
      if (empty_row) begin
        run_o.valid        = 1'b1;
        run_o.is_color_key = 1'b1;
        run_o.run_length   = width_run;
        run_o.row_last     = 1'b1;
      end else if (lp_sat != 15'd0) begin
        run_o.valid        = 1'b1;
        run_o.is_color_key = 1'b1;
        run_o.run_length   = lp_sat;
      end
    end else begin
      unique case (st_i.phase)
        PH_OPCODE, PH_COUNT, PH_GREATER_LOW: begin
          if (st_i.phase == PH_OPCODE && op_kind == OP_END) begin
            run_o.valid        = 1'b1;
            run_o.is_color_key = 1'b1;
            run_o.run_length   = st_i.saved_rp;
            run_o.row_last     = 1'b1;
          end else if (st_i.phase == PH_OPCODE && op_kind == OP_KEY1) begin
            run_o.valid       = 1'b1;
            run_o.pixel_index = SKIP_INDEX;
            run_o.run_length  = 15'd1;
          end else if (use_now && use_cls != CL_DRAW && use_cls != CL_FILL &&
                       use_n != 12'd0) begin
            run_o.valid       = 1'b1;
            run_o.pixel_index = SKIP_INDEX;
            run_o.run_length  = {3'b000, use_n};
          end
        end
        PH_PIXELS: begin
          run_o.valid       = 1'b1;
          run_o.pixel_index = cmd_byte_i;
          run_o.run_length  = 15'd1;
        end
        PH_COLOR: begin
          run_o.valid       = (st_i.pending != 12'd0);
          run_o.pixel_index = cmd_byte_i;
          run_o.run_length  = {3'b000, st_i.pending};
        end
        default: run_o = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sprite_row_rle_decoder.sv @@
// Top level of the sprite row run decoder: stream ports, pipeline registers.
//
// Use: each slave transaction carries either a row start (tuser = 1, with
// left and right padding in tdata) or one command byte of the current row
// (tuser = 0). Each master transaction is one pixel run: a palette index,
// a length, tuser set for key-color padding runs and tlast on a row's final
// run. A transaction that yields no run (counts, opcodes, dropped bytes)
// produces nothing on the master side.
// Config: row_width is written over cfg_valid_i/cfg_ready_o; the user must write it only while the block
// is idle, which the block itself does not enforce; cfg_ready_o is always high.
// Path: a transaction passes the input register, then its run the result register, before the run
// appears on the master side.
// Throughput: 1 transaction per cycle while the master side takes runs; the decoder state is updated in a
// single pass between the input and result registers.
// Stall: when the result register holds an untaken run and m_axis_tready_i
// is low, the input register still takes one more transaction if it is empty; after that
// s_axis_tready_o drops until the run is taken.
// Reset: rst_ni clears both pipeline stages, no row is active and row_width
// returns to 1.
`default_nettype none

module sprite_row_rle_decoder
  import sprr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // cmd_byte[7:0], left_pad[23:8], right_pad[39:24]
  input  logic        s_axis_tuser_i,   // row_start
  // master stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // pixel_index[7:0], run_length[22:8], zero[23]
  output logic        m_axis_tuser_o,   // is_color_key
  output logic        m_axis_tlast_o,   // row_last
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_data_i        // row_width
);

  logic        in_valid_q;
  logic        in_start_q;
  logic [39:0] in_data_q;

  dec_state_t  state_q;
  dec_state_t  state_d;
  run_t        run;

  logic        out_valid_q;
  logic [7:0]  out_index_q;
  logic [14:0] out_len_q;
  logic        out_key_q;
  logic        out_last_q;

  logic [12:0] row_width_q;

  logic        advance;
  logic        consume;

  // result stage can move when its register is empty or being drained
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign consume         = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= 13'd1;
    end else if (cfg_valid_i) begin
      row_width_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_start_q <= s_axis_tuser_i;
      in_data_q  <= s_axis_tdata_i;
    end
  end

  sprr_step u_step (
    .st_i        (state_q),
    .row_width_i (row_width_q),
    .row_start_i (in_start_q),
    .cmd_byte_i  (in_data_q[7:0]),
    .left_pad_i  (in_data_q[23:8]),
    .right_pad_i (in_data_q[39:24]),
    .st_next_o   (state_d),
    .run_o       (run)
  );

  // decoder state advances once per consumed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, pending: '0, cls: CL_DRAW,
                   saved_rp: '0, count_high: '0};
    end else if (consume) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= consume && run.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && run.valid) begin
      out_index_q <= run.pixel_index;
      out_len_q   <= run.run_length;
      out_key_q   <= run.is_color_key;
      out_last_q  <= run.row_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_len_q, out_index_q};
  assign m_axis_tuser_o  = out_key_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTH
  // the final run of a row is always key-color padding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("row end run without key flag");

  // key runs carry index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> (m_axis_tdata_o[7:0] == 8'd0))
    else $error("key run with nonzero index");

  // only the row end run may be empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> (m_axis_tdata_o[22:8] != 15'd0))
    else $error("empty run that is not a row end");

  // a row end leaves no row active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && run.valid && run.row_last |=> (state_q.phase == PH_IDLE))
    else $error("row still active after row end run");

  // a held input transaction is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_data_q) && $stable(in_start_q))
    else $error("input register lost a transaction");
`endif

endmodule

`default_nettype wire
